[rtl/plsm_pkg.sv]
// ----------------------------------------------------------------------------
// plsm_pkg: shared types and constants of the sum minimizer
// Word formats, sequencer states, breakpoint kinds and saturating arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none
package plsm_pkg;

  typedef struct packed {
    logic [31:0]        low_bound;
    logic [31:0]        high_bound;
    logic signed [31:0] coef_first;
    logic signed [31:0] coef_second;
    logic signed [31:0] coef_third;
    logic signed [31:0] coef_fourth;
    logic               last;
  } fn_word_t;

  typedef struct packed {
    logic [31:0] least_point;
    logic        found;
  } res_word_t;

  typedef enum logic [4:0] {
    S_LOAD,
    S_B_RD, S_B_MUL, S_B_W0, S_B_W1, S_B_W2,
    S_SORT_KEY, S_SORT_KEYW, S_SORT_RD, S_SORT_CMP,
    S_SW_INIT, S_SW_INITW, S_SW_RD, S_SW_UPD,
    S_SW_M1, S_SW_M1W, S_SW_M2, S_SW_M2W, S_SW_FIN,
    S_DONE
  } state_t;

  localparam logic [1:0] KIND_LOW   = 2'd0;
  localparam logic [1:0] KIND_HIGH  = 2'd1;
  localparam logic [1:0] KIND_MICRO = 2'd2;

  localparam logic signed [63:0] SCORE_LIMIT = 64'sd6553600000;
  localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};
  localparam logic [15:0] MICRO_RESET = 16'd655;

  // Two's complement add that clamps to the 64-bit signed range.
  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      sat_add = a[63] ? S64_MIN : S64_MAX;
    end else begin
      sat_add = s;
    end
  endfunction

endpackage
`default_nettype wire

[rtl/plsm_mulshift.sv]
// ----------------------------------------------------------------------------
// plsm_mulshift: iterative signed term times point product
// Forms floor(coef * point / 65536), saturated to 64 bits, from four
// 32x32 partial products taken one per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module plsm_mulshift #(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic signed [63:0]       coef,
  input  wire logic [VALUE_WIDTH-1:0]   point,
  output logic                          done,
  output logic signed [63:0]            result
);
  import plsm_pkg::*;

  logic [63:0]  mag;
  logic [63:0]  pnt;
  logic         neg;
  logic         busy;
  logic [2:0]   cnt;
  logic         mulv;
  logic [63:0]  pp;
  logic [1:0]   psh;
  logic [127:0] acc;

  logic [31:0]  a_sel;
  logic [31:0]  b_sel;
  logic [63:0]  q;
  logic [63:0]  q_inc;
  logic         over;
  logic         frac;
  logic         over_n;

  assign a_sel = cnt[1] ? mag[63:32] : mag[31:0];
  assign b_sel = cnt[0] ? pnt[63:32] : pnt[31:0];

  assign q      = acc[79:16];
  assign over   = acc[127:80] != 48'd0;
  assign frac   = acc[15:0] != 16'd0;
  assign q_inc  = q + {63'd0, frac};
  assign over_n = over || (frac && q == {64{1'b1}});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      mulv <= 1'b0;
      done <= 1'b0;
      cnt  <= 3'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        mulv <= 1'b0;
        cnt  <= 3'd0;
        neg  <= coef[63];
        mag  <= coef[63] ? 64'(-coef) : 64'(coef);
        pnt  <= 64'(point);
        acc  <= 128'd0;
      end else if (busy) begin
        if (cnt != 3'd4) begin
          pp   <= a_sel * b_sel;
          psh  <= {1'b0, cnt[1]} + {1'b0, cnt[0]};
          mulv <= 1'b1;
          cnt  <= cnt + 3'd1;
        end else begin
          mulv <= 1'b0;
        end
        if (mulv) begin
          acc <= acc + ({64'd0, pp} << (7'd32 * psh));
        end
        if (cnt == 3'd4 && !mulv) begin
          busy <= 1'b0;
          done <= 1'b1;
          if (!neg) begin
            result <= (over || q[63]) ? S64_MAX : q;
          end else begin
            result <= (over_n || q_inc[63]) ? S64_MIN : -q_inc;
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

[rtl/piecewise_linear_sum_minimizer.sv]
// ----------------------------------------------------------------------------
// piecewise_linear_sum_minimizer: least-score breakpoint of a function set
// Loads function records, sorts their breakpoints and sweeps them with a
// shared multiply unit to find the breakpoint of least summed score.
// ----------------------------------------------------------------------------
// Usage. Function records arrive as words on the fn channel (fn_valid,
// fn_stall, fn_data). A word is taken when fn_valid is high and fn_stall low.
// Records are taken back to back while the block is loading. The word with
// last set closes the set; fn_stall then stays high while the block builds
// three breakpoints per record, insertion-sorts the 3N breakpoints in the
// point memory and sweeps them, using the four-step multiply unit twice per
// point. One result word then appears on the res channel and is held while
// res_stall is high; the next set may load meanwhile, and a second result
// waits in the final state until the first one is taken.
// Reset clears the set state and sets micro_fraction to 655; the record and
// point memories are not cleared, since only entries of the current set are
// ever read. micro_fraction is written through the APB port at address 0.
// ----------------------------------------------------------------------------
`default_nettype none
module piecewise_linear_sum_minimizer #(
  parameter int MAX_FUNCTIONS = 256,
  parameter int VALUE_WIDTH   = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 fn_valid,
  output logic                      fn_stall,
  input  wire plsm_pkg::fn_word_t   fn_data,
  output logic                      res_valid,
  input  wire logic                 res_stall,
  output plsm_pkg::res_word_t       res_data,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [2:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import plsm_pkg::*;

  localparam int VW      = VALUE_WIDTH;
  localparam int RW      = (MAX_FUNCTIONS > 1) ? $clog2(MAX_FUNCTIONS) : 1;
  localparam int CW      = $clog2(MAX_FUNCTIONS + 1);
  localparam int NPTS    = 3 * MAX_FUNCTIONS;
  localparam int PIW     = $clog2(NPTS);
  localparam int NW      = $clog2(NPTS + 1);
  localparam int PW      = VW + RW + 2;
  localparam int LEVEL_W = 33 + CW;

  // Configuration register.
  logic [15:0] micro_fraction;
  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {16'd0, micro_fraction};

  always_ff @(posedge clk) begin
    if (rst) begin
      micro_fraction <= MICRO_RESET;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      micro_fraction <= pwdata[15:0];
    end
  end

  // Record memories and the point memory.
  logic [VW-1:0]  low_mem  [MAX_FUNCTIONS];
  logic [VW-1:0]  high_mem [MAX_FUNCTIONS];
  logic [127:0]   coef_mem [MAX_FUNCTIONS];
  logic [PW-1:0]  pt_mem   [NPTS];

  logic [VW-1:0]  low_rd;
  logic [VW-1:0]  high_rd;
  logic [127:0]   coef_rd;
  logic [PW-1:0]  pt_rd;

  state_t state, state_next;

  logic [CW-1:0]             count;
  logic signed [LEVEL_W-1:0] level_sum;
  logic [NW-1:0]             n_pts;
  logic [NW-1:0]             i_idx;
  logic [NW-1:0]             j_idx;
  logic [RW-1:0]             b_rec;
  logic [VW-1:0]             low_q;
  logic [VW-1:0]             high_q;
  logic [VW+15:0]            micro_prod;
  logic [PW-1:0]             key;
  logic [PW-1:0]             prev;
  logic [VW-1:0]             cur_val;
  logic signed [63:0]        t0, t1, t2, t3;
  logic signed [63:0]        score;
  logic signed [63:0]        least_score;
  logic [VW-1:0]             best_point;

  logic                      load_fire;
  logic                      rec_room;
  logic [RW-1:0]             rec_raddr;
  logic [PIW-1:0]            pt_raddr;
  logic                      pt_we;
  logic [PIW-1:0]            pt_waddr;
  logic [PW-1:0]             pt_wdata;
  logic                      ms_start;
  logic signed [63:0]        ms_coef;
  logic                      ms_done;
  logic signed [63:0]        ms_result;
  logic [VW:0]               micro_sum;
  logic [VW-1:0]             micro_val;
  logic                      key_less;
  logic                      last_i;
  logic signed [63:0]        score_fin;
  logic                      sweep_end;

  assign fn_stall  = (state != S_LOAD);
  assign load_fire = fn_valid && !fn_stall;
  assign rec_room  = count < CW'(MAX_FUNCTIONS);

  always_ff @(posedge clk) begin
    if (load_fire && rec_room) begin
      low_mem[count[RW-1:0]]  <= VW'(fn_data.low_bound);
      high_mem[count[RW-1:0]] <= VW'(fn_data.high_bound);
      coef_mem[count[RW-1:0]] <= {fn_data.coef_fourth, fn_data.coef_third,
                                  fn_data.coef_second, fn_data.coef_first};
    end
    low_rd  <= low_mem[rec_raddr];
    high_rd <= high_mem[rec_raddr];
    coef_rd <= coef_mem[rec_raddr];
  end

  always_ff @(posedge clk) begin
    if (pt_we) begin
      pt_mem[pt_waddr] <= pt_wdata;
    end
    pt_rd <= pt_mem[pt_raddr];
  end

  // Micro breakpoint: high plus its scaled fraction, clamped to the value range.
  assign micro_sum = {1'b0, high_q} + {1'b0, micro_prod[VW+15:16]};
  assign micro_val = micro_sum[VW] ? {VW{1'b1}} : micro_sum[VW-1:0];

  // Breakpoint order is value, then record, then kind: one unsigned compare.
  assign key_less  = key < pt_rd;
  assign last_i    = (i_idx + NW'(1)) == n_pts;
  assign score_fin = sat_add(score, t3);
  assign sweep_end = (j_idx + NW'(1)) == n_pts;
  assign ms_coef   = (state == S_SW_M1) ? t1 : t2;

  plsm_mulshift #(.VALUE_WIDTH(VW)) u_mulshift (
    .clk    (clk),
    .rst    (rst),
    .start  (ms_start),
    .coef   (ms_coef),
    .point  (cur_val),
    .done   (ms_done),
    .result (ms_result)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_LOAD:      if (load_fire && fn_data.last) state_next = S_B_RD;
      S_B_RD:      state_next = S_B_MUL;
      S_B_MUL:     state_next = S_B_W0;
      S_B_W0:      state_next = S_B_W1;
      S_B_W1:      state_next = S_B_W2;
      S_B_W2:      state_next = ((CW'(b_rec) + CW'(1)) == count) ? S_SORT_KEY : S_B_RD;
      S_SORT_KEY:  state_next = S_SORT_KEYW;
      S_SORT_KEYW: state_next = S_SORT_RD;
      S_SORT_RD: begin
        if (j_idx != NW'(0)) begin
          state_next = S_SORT_CMP;
        end else begin
          state_next = last_i ? S_SW_INIT : S_SORT_KEY;
        end
      end
      S_SORT_CMP: begin
        if (key_less) begin
          state_next = S_SORT_RD;
        end else begin
          state_next = last_i ? S_SW_INIT : S_SORT_KEY;
        end
      end
      S_SW_INIT:   state_next = S_SW_INITW;
      S_SW_INITW:  state_next = S_SW_RD;
      S_SW_RD:     state_next = S_SW_UPD;
      S_SW_UPD:    state_next = S_SW_M1;
      S_SW_M1:     state_next = S_SW_M1W;
      S_SW_M1W:    if (ms_done) state_next = S_SW_M2;
      S_SW_M2:     state_next = S_SW_M2W;
      S_SW_M2W:    if (ms_done) state_next = S_SW_FIN;
      S_SW_FIN:    state_next = sweep_end ? S_DONE : S_SW_RD;
      S_DONE:      if (!(res_valid && res_stall)) state_next = S_LOAD;
      default:     state_next = S_LOAD;
    endcase
  end

  // Memory addresses, write strobes and the multiply start.
  always_comb begin
    rec_raddr = prev[RW+1:2];
    pt_raddr  = j_idx[PIW-1:0];
    pt_we     = 1'b0;
    pt_waddr  = j_idx[PIW-1:0];
    pt_wdata  = key;
    ms_start  = 1'b0;
    unique case (state)
      S_B_RD: rec_raddr = b_rec;
      S_B_W0: begin
        pt_we    = 1'b1;
        pt_waddr = i_idx[PIW-1:0];
        pt_wdata = {low_q, b_rec, KIND_LOW};
      end
      S_B_W1: begin
        pt_we    = 1'b1;
        pt_waddr = i_idx[PIW-1:0] + PIW'(1);
        pt_wdata = {high_q, b_rec, KIND_HIGH};
      end
      S_B_W2: begin
        pt_we    = 1'b1;
        pt_waddr = i_idx[PIW-1:0] + PIW'(2);
        pt_wdata = {micro_val, b_rec, KIND_MICRO};
      end
      S_SORT_KEY: pt_raddr = i_idx[PIW-1:0];
      S_SORT_RD: begin
        pt_raddr = j_idx[PIW-1:0] - PIW'(1);
        pt_we    = (j_idx == NW'(0));
      end
      S_SORT_CMP: begin
        pt_we    = 1'b1;
        pt_wdata = key_less ? pt_rd : key;
      end
      S_SW_INIT: pt_raddr = PIW'(0);
      S_SW_M1:   ms_start = 1'b1;
      S_SW_M2:   ms_start = 1'b1;
      default: ;
    endcase
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_LOAD;
      count       <= '0;
      level_sum   <= '0;
      least_score <= SCORE_LIMIT;
      best_point  <= '0;
      res_valid   <= 1'b0;
    end else begin
      state <= state_next;
      // In the final state a taken word is replaced by the new one below.
      if (res_valid && !res_stall && state != S_DONE) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_LOAD: begin
          if (load_fire && rec_room) begin
            count     <= count + CW'(1);
            level_sum <= level_sum + {{(LEVEL_W-32){fn_data.coef_first[31]}},
                                      fn_data.coef_first};
          end
          b_rec <= '0;
          i_idx <= '0;
          if (load_fire && rec_room) begin
            n_pts <= NW'(count + CW'(1)) * NW'(3);
          end else begin
            n_pts <= NW'(count) * NW'(3);
          end
        end
        S_B_MUL: begin
          low_q      <= low_rd;
          high_q     <= high_rd;
          micro_prod <= high_rd * micro_fraction;
        end
        S_B_W2: begin
          b_rec <= b_rec + RW'(1);
          if ((CW'(b_rec) + CW'(1)) == count) begin
            i_idx <= NW'(1);
          end else begin
            i_idx <= i_idx + NW'(3);
          end
        end
        S_SORT_KEYW: begin
          key   <= pt_rd;
          j_idx <= i_idx;
        end
        S_SORT_RD: begin
          if (j_idx == NW'(0)) begin
            i_idx <= i_idx + NW'(1);
          end
        end
        S_SORT_CMP: begin
          if (key_less) begin
            j_idx <= j_idx - NW'(1);
          end else begin
            i_idx <= i_idx + NW'(1);
          end
        end
        S_SW_INITW: begin
          prev  <= pt_rd;
          j_idx <= NW'(1);
          t0    <= -{{(64-LEVEL_W){level_sum[LEVEL_W-1]}}, level_sum};
          t1    <= '0;
          t2    <= '0;
          t3    <= '0;
        end
        S_SW_RD: ;
        S_SW_UPD: begin
          cur_val <= pt_rd[PW-1:RW+2];
          key     <= pt_rd;
          case (prev[1:0])
            KIND_LOW: begin
              t0 <= sat_add(t0, {{32{coef_rd[31]}}, coef_rd[31:0]});
              t1 <= sat_add(t1, -{{32{coef_rd[63]}}, coef_rd[63:32]});
            end
            KIND_HIGH: begin
              t1 <= sat_add(t1, {{32{coef_rd[63]}}, coef_rd[63:32]});
              t2 <= sat_add(t2, {{32{coef_rd[95]}}, coef_rd[95:64]});
              t3 <= sat_add(t3, -{{32{coef_rd[127]}}, coef_rd[127:96]});
            end
            KIND_MICRO: begin
              t2 <= sat_add(t2, -{{32{coef_rd[95]}}, coef_rd[95:64]});
              t3 <= sat_add(t3, {{32{coef_rd[127]}}, coef_rd[127:96]});
            end
            default: ;
          endcase
        end
        S_SW_M1W: if (ms_done) score <= sat_add(t0, ms_result);
        S_SW_M2W: if (ms_done) score <= sat_add(score, ms_result);
        S_SW_FIN: begin
          if (score_fin < least_score) begin
            least_score <= score_fin;
            best_point  <= cur_val;
          end
          prev  <= key;
          j_idx <= j_idx + NW'(1);
        end
        S_DONE: begin
          if (!(res_valid && res_stall)) begin
            res_valid            <= 1'b1;
            res_data.least_point <= 32'(best_point);
            res_data.found       <= least_score < SCORE_LIMIT;
            count                <= '0;
            level_sum            <= '0;
            least_score          <= SCORE_LIMIT;
            best_point           <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // The multiply unit answers only while the sweep waits for it.
  a_ms_done: assert property (@(posedge clk) disable iff (rst)
    ms_done |-> (state == S_SW_M1W || state == S_SW_M2W))
    else $error("multiply result outside its wait state");

  // A compare step always has a point below it.
  a_sort_j: assert property (@(posedge clk) disable iff (rst)
    (state == S_SORT_CMP) |-> (j_idx != NW'(0)))
    else $error("sort compare at the bottom of the memory");

  // Closing a set stops intake on the next cycle.
  a_last_stall: assert property (@(posedge clk) disable iff (rst)
    (load_fire && fn_data.last) |=> fn_stall)
    else $error("intake open after the last record");

  // The record count never passes the capacity.
  a_count: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_FUNCTIONS))
    else $error("record count beyond capacity");

endmodule
`default_nettype wire

[tb/piecewise_linear_sum_minimizer_tb.sv]
// ----------------------------------------------------------------------------
// piecewise_linear_sum_minimizer_tb: self-checking bench of the sum minimizer
// Sends function record sets, predicts the least-score breakpoint of each set
// and compares every result word with the prediction, under random idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module piecewise_linear_sum_minimizer_tb;
  import plsm_pkg::*;

  localparam int MAX_RECORDS = 256;
  localparam int IDLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 60;
  localparam logic [2:0] ADDR_MICRO = 3'd0;
  localparam logic [2:0] ADDR_SPARE = 3'd4;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic fn_valid = 1'b0;
  logic fn_stall;
  fn_word_t fn_data = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_word_t res_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // Idle rates in percent for the sending and the receiving side.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int errors = 0;
  int idle_cycles = 0;

  // Predictor state: the records of the open set and the fraction register.
  fn_word_t open_set[$];
  logic [15:0] micro_frac = 16'd655;
  res_word_t expected_best[$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  piecewise_linear_sum_minimizer dut (
    .clk(clk), .rst(rst),
    .fn_valid(fn_valid), .fn_stall(fn_stall), .fn_data(fn_data),
    .res_valid(res_valid), .res_stall(res_stall), .res_data(res_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Adds two signed 64-bit values and clamps to the signed range.
  function automatic longint clamp_sum(input longint a, input longint b);
    logic signed [64:0] s;
    s = 65'(signed'(a)) + 65'(signed'(b));
    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
    return s[63:0];
  endfunction

  // floor(term * point / 65536), clamped to the signed 64-bit range.
  function automatic longint scaled_product(input longint term, input logic [31:0] point);
    logic signed [127:0] pr;
    pr = $signed({{64{term[63]}}, term}) * $signed({96'b0, point});
    pr = pr >>> 16;
    if (pr > 128'sh7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (pr < -128'sh8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
    return pr[63:0];
  endfunction

  // Builds, sorts and sweeps the breakpoints of the open set. A point key
  // packs value, record and kind so that a plain compare gives the order.
  function automatic res_word_t best_breakpoint();
    logic [43:0] pts[MAX_RECORDS*3];
    logic [43:0] hold;
    logic [63:0] mv;
    logic [31:0] h, p;
    logic [9:0] r;
    logic [1:0] kind;
    longint lvl, t0, t1, t2, t3, s, best, c0, c1, c2, c3;
    logic [31:0] best_pt;
    int cnt, n, i, j;
    res_word_t res;
    cnt = (open_set.size() > MAX_RECORDS) ? MAX_RECORDS : open_set.size();
    n = cnt * 3;
    lvl = 0;
    for (i = 0; i < cnt; i++) begin
      h = open_set[i].high_bound;
      mv = 64'(h) + ((64'(h) * 64'(micro_frac)) >> 16);
      if (mv > 64'hFFFF_FFFF) mv = 64'hFFFF_FFFF;
      r = i[9:0];
      pts[3*i] = {open_set[i].low_bound, r, KIND_LOW};
      pts[3*i+1] = {h, r, KIND_HIGH};
      pts[3*i+2] = {mv[31:0], r, KIND_MICRO};
      lvl = clamp_sum(lvl, longint'(open_set[i].coef_first));
    end
    for (i = 1; i < n; i++) begin
      hold = pts[i];
      j = i;
      while (j > 0 && hold < pts[j-1]) begin
        pts[j] = pts[j-1];
        j--;
      end
      pts[j] = hold;
    end
    t0 = (lvl == 64'sh8000_0000_0000_0000) ? 64'sh7FFF_FFFF_FFFF_FFFF : -lvl;
    t1 = 0; t2 = 0; t3 = 0;
    best = 64'sd6553600000;
    best_pt = '0;
    for (j = 1; j < n; j++) begin
      r = pts[j-1][11:2];
      kind = pts[j-1][1:0];
      p = pts[j][43:12];
      c0 = longint'(open_set[r].coef_first);
      c1 = longint'(open_set[r].coef_second);
      c2 = longint'(open_set[r].coef_third);
      c3 = longint'(open_set[r].coef_fourth);
      if (kind == KIND_LOW) begin
        t0 = clamp_sum(t0, c0);
        t1 = clamp_sum(t1, -c1);
      end else if (kind == KIND_HIGH) begin
        t1 = clamp_sum(t1, c1);
        t2 = clamp_sum(t2, c2);
        t3 = clamp_sum(t3, -c3);
      end else begin
        t2 = clamp_sum(t2, -c2);
        t3 = clamp_sum(t3, c3);
      end
      s = clamp_sum(t0, scaled_product(t1, p));
      s = clamp_sum(s, scaled_product(t2, p));
      s = clamp_sum(s, t3);
      if (s < best) begin
        best = s;
        best_pt = p;
      end
    end
    res.least_point = best_pt;
    res.found = (best < 64'sd6553600000);
    return res;
  endfunction

  // Receiver side: random stall at the falling edge.
  always @(negedge clk) begin
    res_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Result checker, plus the watchdog on cycles with no word accepted.
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (expected_best.size() == 0) begin
        $display("%0t: result word with nothing expected: %h", $time, res_data);
        errors++;
      end else begin
        if (res_data.least_point !== expected_best[0].least_point)
          $display("%0t: least_point expected %h actual %h", $time,
                   expected_best[0].least_point, res_data.least_point);
        if (res_data.found !== expected_best[0].found)
          $display("%0t: found expected %b actual %b", $time,
                   expected_best[0].found, res_data.found);
        if (res_data !== expected_best[0]) errors++;
        void'(expected_best.pop_front());
      end
    end
    if ((fn_valid && !fn_stall) || (res_valid && !res_stall) || rst) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Sends one record word; valid stays high afterwards until the next call
  // or until stop_sending lowers it.
  task automatic send_record(input fn_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      fn_valid = 1'b0;
    end
    @(negedge clk);
    fn_valid = 1'b1;
    fn_data = w;
    forever begin
      @(posedge clk);
      if (!fn_stall) break;
    end
    open_set.push_back(w);
    if (w.last) begin
      expected_best.push_back(best_breakpoint());
      open_set.delete();
    end
  endtask

  task automatic stop_sending();
    @(negedge clk);
    fn_valid = 1'b0;
  endtask

  // Waits until every expected word has come and the block has settled.
  task automatic drain();
    stop_sending();
    while (expected_best.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
    @(negedge clk);
    psel = 1'b1; pwrite = 1'b1; paddr = addr; pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    if (addr == ADDR_MICRO) micro_frac = value[15:0];
  endtask

  function automatic logic [31:0] rand_bound();
    case ($urandom_range(3))
      0: return $urandom();
      1: return $urandom_range(32'h000F_FFFF);
      2: return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
      default: return $urandom_range(32'h0400_0000);
    endcase
  endfunction

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(4))
      0: return $urandom();
      1: return 32'($urandom_range(32'h0008_0000)) - 32'h0004_0000;
      2: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      3: return '0;
      default: return 32'($urandom_range(32'h0001_0000)) - 32'h0000_8000;
    endcase
  endfunction

  function automatic fn_word_t rand_record(input logic last);
    fn_word_t w;
    w.low_bound = rand_bound();
    w.high_bound = rand_bound();
    w.coef_first = rand_coef();
    w.coef_second = rand_coef();
    w.coef_third = rand_coef();
    w.coef_fourth = rand_coef();
    w.last = last;
    return w;
  endfunction

  function automatic fn_word_t make_record(input logic [31:0] lo, hi, c0, c1, c2, c3,
                                           input logic last);
    fn_word_t w;
    w.low_bound = lo; w.high_bound = hi;
    w.coef_first = c0; w.coef_second = c1; w.coef_third = c2; w.coef_fourth = c3;
    w.last = last;
    return w;
  endfunction

  // Field extremes, equal breakpoints and a micro point that saturates.
  task automatic test_edge_records();
    send_record(make_record(0, 0, 0, 0, 0, 0, 1'b1));
    send_record(make_record(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1));
    send_record(make_record(0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                            32'h8000_0000, 32'h8000_0000, 1'b1));
    // Identical records: ties fall back to load order, then kind.
    send_record(make_record(32'h0001_0000, 32'h0002_0000, 32'h0000_8000,
                            32'hFFFF_0000, 32'h0001_0000, 32'h0000_4000, 1'b0));
    send_record(make_record(32'h0001_0000, 32'h0002_0000, 32'h0000_8000,
                            32'hFFFF_0000, 32'h0001_0000, 32'h0000_4000, 1'b1));
    // Micro point beyond the value range, with a level that scores low.
    send_record(make_record(32'hFFFF_0000, 32'hFFFF_FFF0, 32'hFFF0_0000,
                            32'h0000_0100, 32'hFFFF_FF00, 32'h0001_0000, 1'b0));
    send_record(make_record(32'h0000_1000, 32'h8000_0000, 32'h0010_0000,
                            32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0));
    send_record(make_record(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                            32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 1'b1));
    for (int i = 0; i < 8; i++) send_record(rand_record(i % 3 == 2 || i == 7));
    drain();
  endtask

  // More records than the store holds; the dropped last record closes the
  // set. Points come almost in order so the sort stays short.
  task automatic test_record_overflow();
    logic [31:0] lo;
    for (int i = 0; i < MAX_RECORDS + 2; i++) begin
      lo = i << 20;
      send_record(make_record(lo, lo + 32'd16, 32'($urandom_range(255)) - 32'd128,
                              rand_coef(), rand_coef(), rand_coef(),
                              i == MAX_RECORDS + 1));
    end
    drain();
  endtask

  // Register extremes, a write to an unused address, and short sets under each.
  task automatic test_fraction_settings();
    logic [31:0] settings[4];
    settings = '{32'h0, 32'hFFFF_FFFF, 32'h0000_8000, $urandom()};
    foreach (settings[k]) begin
      write_reg(ADDR_MICRO, settings[k]);
      write_reg(ADDR_SPARE, $urandom());
      for (int i = 0; i < 6; i++) send_record(rand_record(i % 2 == 1));
      drain();
    end
  endtask

  // Random sets, mostly small, a few of 20 to 40 records; now and then the
  // sender holds until every result is back, and may then change the fraction.
  task automatic test_random_sets(input int items);
    int sent, len;
    sent = 0;
    while (sent < items) begin
      len = ($urandom_range(49) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      for (int i = 0; i < len; i++) send_record(rand_record(i == len - 1));
      sent += len;
      if ($urandom_range(19) == 0) begin
        drain();
        if ($urandom_range(1)) write_reg(ADDR_MICRO, $urandom());
      end
    end
    drain();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_edge_records();
    test_fraction_settings();
    write_reg(ADDR_MICRO, 32'd655);
    test_record_overflow();
    send_idle_pct = 10; recv_idle_pct = 67;
    test_random_sets(350);
    send_idle_pct = 67; recv_idle_pct = 10;
    test_random_sets(350);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random_sets(350);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
